// ----- design/lcgnp_pkg.sv -----
package lcgnp_pkg;

    localparam logic [31:0] LCG_MUL     = 32'd1103515245;
    localparam logic [31:0] LCG_ADD     = 32'd12345;
    localparam logic [7:0]  RESIDUE_MOD = 8'd99;

    localparam int SEED_W   = 32;
    localparam int THRESH_W = 7;
    localparam int COLOR_W  = 32;
    localparam int VALUE_W  = 31;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_START_SEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_BELOW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_ABOVE = 2'd3;

    localparam logic [SEED_W-1:0]   START_SEED_RST  = 32'h0000_0000;
    localparam logic [THRESH_W-1:0] THRESHOLD_RST   = 7'd50;
    localparam logic [COLOR_W-1:0]  COLOR_BELOW_RST = 32'hFFFF_FFFF;
    localparam logic [COLOR_W-1:0]  COLOR_ABOVE_RST = 32'h0000_0000;

    typedef struct packed {
        logic       accept;
        logic       step_en;
        logic       step_first;
        logic       mod_en;
        logic       mod_first;
        logic [1:0] mod_sel;
        logic       out_load;
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_STEP = 4'b0010,
        ST_MOD  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

endpackage

// ----- design/lcgnp_ctrl.sv -----
module lcgnp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output lcgnp_pkg::cmd_t   cmd
);

    lcgnp_pkg::state_t state_reg;
    lcgnp_pkg::state_t state_next;
    logic [1:0]        cnt_reg;
    logic [1:0]        cnt_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_free;

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != lcgnp_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        cmd.step_first = (cnt_reg == 2'd0);
        cmd.mod_first  = (cnt_reg == 2'd0);
        cmd.mod_sel    = cnt_reg;
        unique case (state_reg)
            lcgnp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    cnt_next   = 2'd0;
                    state_next = lcgnp_pkg::ST_STEP;
                end
            end
            lcgnp_pkg::ST_STEP:
            begin
                cmd.step_en = 1'b1;
                if (cnt_reg == 2'd2)
                begin
                    cnt_next   = 2'd0;
                    state_next = lcgnp_pkg::ST_MOD;
                end
                else
                begin
                    cnt_next = cnt_reg + 2'd1;
                end
            end
            lcgnp_pkg::ST_MOD:
            begin
                cmd.mod_en = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                if (cnt_reg == 2'd3)
                begin
                    state_next = lcgnp_pkg::ST_DONE;
                end
            end
            lcgnp_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = lcgnp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lcgnp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lcgnp_pkg::ST_IDLE;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- design/lcgnp_datapath.sv -----
module lcgnp_datapath
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  lcgnp_pkg::cmd_t                        cmd,
    input  logic                                   first_pixel,
    input  logic                                   cfg_we,
    input  logic [lcgnp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcgnp_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic [lcgnp_pkg::COLOR_W-1:0]          pixel_color,
    output logic [lcgnp_pkg::VALUE_W-1:0]          random_value
);

    logic [lcgnp_pkg::SEED_W-1:0]   start_seed_reg;
    logic [lcgnp_pkg::THRESH_W-1:0] threshold_reg;
    logic [lcgnp_pkg::COLOR_W-1:0]  color_below_reg;
    logic [lcgnp_pkg::COLOR_W-1:0]  color_above_reg;

    logic [lcgnp_pkg::SEED_W-1:0]   seed_state_reg;
    logic                           first_reg;
    logic [lcgnp_pkg::VALUE_W-1:0]  val_reg;
    logic [lcgnp_pkg::VALUE_W-1:0]  val_next;
    logic [6:0]                     rem_reg;
    logic [6:0]                     rem_next;
    logic [lcgnp_pkg::COLOR_W-1:0]  color_reg;
    logic [lcgnp_pkg::VALUE_W-1:0]  value_reg;

    logic [lcgnp_pkg::SEED_W-1:0]   lcg_src;
    logic [lcgnp_pkg::SEED_W-1:0]   lcg_next;
    logic [31:0]                    val_padded;
    logic [1:0]                     byte_sel;
    logic [7:0]                     mod_bits;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_seed_reg  <= lcgnp_pkg::START_SEED_RST;
            threshold_reg   <= lcgnp_pkg::THRESHOLD_RST;
            color_below_reg <= lcgnp_pkg::COLOR_BELOW_RST;
            color_above_reg <= lcgnp_pkg::COLOR_ABOVE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcgnp_pkg::REG_START_SEED:  start_seed_reg  <= cfg_data;
                lcgnp_pkg::REG_THRESHOLD:   threshold_reg   <= cfg_data[lcgnp_pkg::THRESH_W-1:0];
                lcgnp_pkg::REG_COLOR_BELOW: color_below_reg <= cfg_data;
                lcgnp_pkg::REG_COLOR_ABOVE: color_above_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // The first step of a pixel marked as the first of an image starts from the seed.
    assign lcg_src  = (cmd.step_first && first_reg) ? start_seed_reg : seed_state_reg;
    assign lcg_next = (lcg_src * lcgnp_pkg::LCG_MUL) + lcgnp_pkg::LCG_ADD;

    always_comb
    begin
        if (cmd.step_first)
        begin
            val_next = {20'd0, lcg_next[26:16]};
        end
        else
        begin
            val_next = {val_reg[20:0], 10'd0} ^ {21'd0, lcg_next[25:16]};
        end
    end

    assign val_padded = {1'b0, val_reg};
    assign byte_sel   = 2'd3 - cmd.mod_sel;
    assign mod_bits   = val_padded[{byte_sel, 3'b000} +: 8];

    // Restoring reduction modulo 99, one byte of the value per cycle, top byte first.
    always_comb
    begin
        logic [7:0] trial;
        logic [6:0] acc;
        acc = cmd.mod_first ? 7'd0 : rem_reg;
        for (int i = 7; i >= 0; i--)
        begin
            trial = {acc, mod_bits[i]};
            if (trial >= lcgnp_pkg::RESIDUE_MOD)
            begin
                trial = trial - lcgnp_pkg::RESIDUE_MOD;
            end
            acc = trial[6:0];
        end
        rem_next = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_state_reg <= '0;
        end
        else if (cmd.step_en)
        begin
            seed_state_reg <= lcg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            first_reg <= first_pixel;
        end
        if (cmd.step_en)
        begin
            val_reg <= val_next;
        end
        if (cmd.mod_en)
        begin
            rem_reg <= rem_next;
        end
        if (cmd.out_load)
        begin
            color_reg <= (rem_reg < threshold_reg) ? color_below_reg : color_above_reg;
            value_reg <= val_reg;
        end
    end

    assign pixel_color  = color_reg;
    assign random_value = value_reg;

endmodule

// ----- design/lcg_noise_pixel_generator_unit.sv -----
// Each item runs three dependent LCG steps through the single 32-bit multiplier, then
// four byte steps of the byte-serial modulo-99 unit; a new item waits (in_stall)
// until the result is loaded, which waits while a held result is stalled at the output.
// A new item is accepted while the previous result still waits in the output register.
// Reset (rst_n low, asynchronous) clears the seed state to zero and loads the
// register defaults: seed 0, threshold 50, colour below all ones, colour above zero.
module lcg_noise_pixel_generator_unit
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic                                   first_pixel,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [lcgnp_pkg::COLOR_W-1:0]          pixel_color,
    output logic [lcgnp_pkg::VALUE_W-1:0]          random_value,
    input  logic                                   cfg_we,
    input  logic [lcgnp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lcgnp_pkg::CFG_DATA_W-1:0]       cfg_data
);

    lcgnp_pkg::cmd_t cmd;

    lcgnp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    lcgnp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .first_pixel  (first_pixel),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_color  (pixel_color),
        .random_value (random_value)
    );

endmodule
